// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers for the quaternion conversion checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define RMQ_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// assertion on clk_i and rst_ni
`define RMQ_ASSERT(lbl, prop, msg) `RMQ_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== hdl/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// types, constants and step functions of the matrix to quaternion pipeline
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int DW        = 16;
  localparam int ARG_W     = 18;
  localparam int OP_W      = 17;
  localparam int ROOT_W    = 16;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int SREM_W    = ROOT_W + 1;
  localparam int K_W       = 21;
  localparam int DREM_W    = ROOT_W + 1;
  localparam int PROD_W    = OP_W + K_W;
  localparam int RND_W     = PROD_W - FRAC_BITS;
  localparam int SQ_STEPS  = ROOT_W;
  localparam int SQ_PER    = 4;
  localparam int SQ_STG    = SQ_STEPS / SQ_PER;
  localparam int DV_STEPS  = K_W;
  localparam int DV_PER    = 3;
  localparam int DV_STG    = DV_STEPS / DV_PER;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_XDOM  = 2'd1,
    BR_YDOM  = 2'd2,
    BR_ZDOM  = 2'd3
  } branch_e;

  typedef struct packed {
    logic signed [DW-1:0] m11;
    logic signed [DW-1:0] m12;
    logic signed [DW-1:0] m13;
    logic signed [DW-1:0] m21;
    logic signed [DW-1:0] m22;
    logic signed [DW-1:0] m23;
    logic signed [DW-1:0] m31;
    logic signed [DW-1:0] m32;
    logic signed [DW-1:0] m33;
  } in_t;

  typedef struct packed {
    logic signed [DW-1:0] qw;
    logic signed [DW-1:0] qx;
    logic signed [DW-1:0] qy;
    logic signed [DW-1:0] qz;
    branch_e              branch_taken;
    logic                 degenerate;
  } out_t;

  typedef struct packed {
    branch_e                br;
    logic                   degen;
    logic signed [OP_W-1:0] opa;
    logic signed [OP_W-1:0] opb;
    logic signed [OP_W-1:0] opc;
  } front_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    front_t            fr;
  } rt_t;

  typedef struct packed {
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sq_st_t;

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [DREM_W-1:0] dvs;
    logic [K_W-1:0]    num;
    logic [K_W-1:0]    quo;
  } dv_st_t;

  // one digit of the square root recurrence
  function automatic sq_st_t sq_step(sq_st_t s);
    logic [SREM_W+1:0] r2;
    logic [SREM_W+1:0] trial;
    sq_st_t            n;
    r2    = {s.rem, s.rad[RAD_W-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    n.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (r2 >= trial) begin
      n.rem  = SREM_W'(r2 - trial);
      n.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      n.rem  = r2[SREM_W-1:0];
      n.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return n;
  endfunction

  // one quotient bit of the restoring divider
  function automatic dv_st_t dv_step(dv_st_t s);
    logic [DREM_W:0] r2;
    logic [DREM_W:0] d;
    dv_st_t          n;
    r2    = {s.rem, s.num[K_W-1]};
    d     = {1'b0, s.dvs};
    n.dvs = s.dvs;
    n.num = {s.num[K_W-2:0], 1'b0};
    if (r2 >= d) begin
      n.rem = DREM_W'(r2 - d);
      n.quo = {s.quo[K_W-2:0], 1'b1};
    end else begin
      n.rem = r2[DREM_W-1:0];
      n.quo = {s.quo[K_W-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

// ===== hdl/rotation_matrix_to_quaternion_core.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// 3x3 rotation matrix in signed q2.14 to quaternion, pipelined
// ----------------------------------------------------------------------------
// stages: 1 select, 4 square root, 7 divider, 1 multiply, 1 round
// throughput: one item per cycle unless out_stall_i holds the output,
// set by the fully pipelined root and divider
// reset clears all stage valid bits; data registers are not reset
module rotation_matrix_to_quaternion_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rmq_pkg::in_t  in_item_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rmq_pkg::out_t out_item_o
);

  logic                       f_valid, f_stall;
  logic [rmq_pkg::RAD_W-1:0]  f_rad;
  rmq_pkg::front_t            f_fr;
  logic                       s_valid, s_stall;
  logic [rmq_pkg::ROOT_W-1:0] s_root;
  rmq_pkg::front_t            s_fr;
  rmq_pkg::rt_t               s_rt;
  logic                       d_valid, d_stall;
  logic [rmq_pkg::K_W-1:0]    d_k;
  rmq_pkg::rt_t               d_rt;

  rmq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .item_i  (in_item_i),
    .valid_o (f_valid),
    .stall_i (f_stall),
    .rad_o   (f_rad),
    .fr_o    (f_fr)
  );

  rmq_isqrt #(
    .SIDE_W ($bits(rmq_pkg::front_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .stall_o (f_stall),
    .rad_i   (f_rad),
    .side_i  (f_fr),
    .valid_o (s_valid),
    .stall_i (s_stall),
    .root_o  (s_root),
    .side_o  (s_fr)
  );

  assign s_rt = '{root: s_root, fr: s_fr};

  rmq_recip #(
    .SIDE_W ($bits(rmq_pkg::rt_t))
  ) u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid),
    .stall_o (s_stall),
    .root_i  (s_root),
    .side_i  (s_rt),
    .valid_o (d_valid),
    .stall_i (d_stall),
    .k_o     (d_k),
    .side_o  (d_rt)
  );

  rmq_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_valid),
    .stall_o (d_stall),
    .k_i     (d_k),
    .rt_i    (d_rt),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .item_o  (out_item_o)
  );

endmodule

// ===== hdl/rmq_front.sv =====
// ----------------------------------------------------------------------------
// rmq_front
// branch choice, square root argument and the three operands to be scaled
// ----------------------------------------------------------------------------
module rmq_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  rmq_pkg::in_t              item_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic [rmq_pkg::RAD_W-1:0] rad_o,
  output rmq_pkg::front_t           fr_o
);

  localparam logic signed [rmq_pkg::ARG_W-1:0] One = rmq_pkg::ARG_W'(1 << rmq_pkg::FRAC_BITS);

  logic                              valid_q;
  logic                              stl;
  logic signed [rmq_pkg::ARG_W-1:0]  e11, e22, e33, t, arg;
  logic signed [rmq_pkg::OP_W-1:0]   s12, s13, s23, d32, d13, d21;
  rmq_pkg::front_t                   fr_d, fr_q;
  logic [rmq_pkg::RAD_W-1:0]         rad_d, rad_q;

  always_comb begin
    e11 = rmq_pkg::ARG_W'(item_i.m11);
    e22 = rmq_pkg::ARG_W'(item_i.m22);
    e33 = rmq_pkg::ARG_W'(item_i.m33);
    t   = e11 + e22 + e33;
    s12 = rmq_pkg::OP_W'(item_i.m12) + rmq_pkg::OP_W'(item_i.m21);
    s13 = rmq_pkg::OP_W'(item_i.m13) + rmq_pkg::OP_W'(item_i.m31);
    s23 = rmq_pkg::OP_W'(item_i.m23) + rmq_pkg::OP_W'(item_i.m32);
    d32 = rmq_pkg::OP_W'(item_i.m32) - rmq_pkg::OP_W'(item_i.m23);
    d13 = rmq_pkg::OP_W'(item_i.m13) - rmq_pkg::OP_W'(item_i.m31);
    d21 = rmq_pkg::OP_W'(item_i.m21) - rmq_pkg::OP_W'(item_i.m12);
    if (t > 0) begin
      fr_d.br = rmq_pkg::BR_TRACE;
      arg     = t + One;
      fr_d.opa = d32; fr_d.opb = d13; fr_d.opc = d21;
    end else if (item_i.m11 >= item_i.m22 && item_i.m11 >= item_i.m33) begin
      fr_d.br = rmq_pkg::BR_XDOM;
      arg     = e11 - e22 - e33 + One;
      fr_d.opa = s12; fr_d.opb = s13; fr_d.opc = d32;
    end else if (item_i.m22 >= item_i.m33) begin
      fr_d.br = rmq_pkg::BR_YDOM;
      arg     = e22 - e11 - e33 + One;
      fr_d.opa = s12; fr_d.opb = s23; fr_d.opc = d13;
    end else begin
      fr_d.br = rmq_pkg::BR_ZDOM;
      arg     = e33 - e22 - e11 + One;
      fr_d.opa = s13; fr_d.opb = s23; fr_d.opc = d21;
    end
    fr_d.degen = arg[rmq_pkg::ARG_W-1] || (arg == '0);
    rad_d = fr_d.degen ? '0
          : (rmq_pkg::RAD_W'(arg[rmq_pkg::ARG_W-2:0]) << rmq_pkg::FRAC_BITS);
  end

  assign stl     = valid_q && stall_i;
  assign stall_o = stl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stl) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stl) begin
      fr_q  <= fr_d;
      rad_q <= rad_d;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign fr_o    = fr_q;

endmodule

// ===== hdl/rmq_isqrt.sv =====
// ----------------------------------------------------------------------------
// rmq_isqrt
// pipelined integer square root, several digits per stage
// ----------------------------------------------------------------------------
module rmq_isqrt #(
  parameter int SIDE_W = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  logic [rmq_pkg::RAD_W-1:0]  rad_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       valid_o,
  input  logic                       stall_i,
  output logic [rmq_pkg::ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0]          side_o
);

  localparam int N = rmq_pkg::SQ_STG;

  logic [N-1:0]       vq;
  logic [N-1:0]       stl;
  rmq_pkg::sq_st_t    st_q   [N];
  logic [SIDE_W-1:0]  side_q [N];

  for (genvar s = 0; s < N; s++) begin : g_stg
    rmq_pkg::sq_st_t   st_in, st_d;
    logic              v_in;
    logic [SIDE_W-1:0] sd_in;

    if (s == 0) begin : g_first
      assign st_in = '{rem: '0, root: '0, rad: rad_i};
      assign v_in  = valid_i;
      assign sd_in = side_i;
    end else begin : g_next
      assign st_in = st_q[s-1];
      assign v_in  = vq[s-1];
      assign sd_in = side_q[s-1];
    end

    if (s == N - 1) begin : g_last
      assign stl[s] = vq[s] && stall_i;
    end else begin : g_mid
      assign stl[s] = vq[s] && stl[s+1];
    end

    always_comb begin
      st_d = st_in;
      for (int i = 0; i < rmq_pkg::SQ_PER; i++) begin
        st_d = rmq_pkg::sq_step(st_d);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vq[s] <= 1'b0;
      end else if (!stl[s]) begin
        vq[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (!stl[s]) begin
        st_q[s]   <= st_d;
        side_q[s] <= sd_in;
      end
    end
  end

  assign stall_o = stl[0];
  assign valid_o = vq[N-1];
  assign root_o  = st_q[N-1].root;
  assign side_o  = side_q[N-1];

endmodule

// ===== hdl/rmq_recip.sv =====
// ----------------------------------------------------------------------------
// rmq_recip
// pipelined restoring divider for k = (one^2 + root) / (2 root)
// ----------------------------------------------------------------------------
module rmq_recip #(
  parameter int SIDE_W = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  logic [rmq_pkg::ROOT_W-1:0] root_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       valid_o,
  input  logic                       stall_i,
  output logic [rmq_pkg::K_W-1:0]    k_o,
  output logic [SIDE_W-1:0]          side_o
);

  localparam int N = rmq_pkg::DV_STG;
  // leading numerator bits above the quotient range
  localparam logic [rmq_pkg::DREM_W-1:0] RemInit =
    rmq_pkg::DREM_W'(1 << (2 * rmq_pkg::FRAC_BITS - rmq_pkg::K_W));

  logic [N-1:0]       vq;
  logic [N-1:0]       stl;
  rmq_pkg::dv_st_t    st_q   [N];
  logic [SIDE_W-1:0]  side_q [N];

  for (genvar s = 0; s < N; s++) begin : g_stg
    rmq_pkg::dv_st_t   st_in, st_d;
    logic              v_in;
    logic [SIDE_W-1:0] sd_in;

    if (s == 0) begin : g_first
      assign st_in = '{rem: RemInit, dvs: {root_i, 1'b0},
                       num: rmq_pkg::K_W'(root_i), quo: '0};
      assign v_in  = valid_i;
      assign sd_in = side_i;
    end else begin : g_next
      assign st_in = st_q[s-1];
      assign v_in  = vq[s-1];
      assign sd_in = side_q[s-1];
    end

    if (s == N - 1) begin : g_last
      assign stl[s] = vq[s] && stall_i;
    end else begin : g_mid
      assign stl[s] = vq[s] && stl[s+1];
    end

    always_comb begin
      st_d = st_in;
      for (int i = 0; i < rmq_pkg::DV_PER; i++) begin
        st_d = rmq_pkg::dv_step(st_d);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vq[s] <= 1'b0;
      end else if (!stl[s]) begin
        vq[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (!stl[s]) begin
        st_q[s]   <= st_d;
        side_q[s] <= sd_in;
      end
    end
  end

  assign stall_o = stl[0];
  assign valid_o = vq[N-1];
  assign k_o     = st_q[N-1].quo;
  assign side_o  = side_q[N-1];

endmodule

// ===== hdl/rmq_back.sv =====
// ----------------------------------------------------------------------------
// rmq_back
// scaling products, rounding, saturation and component placement
// ----------------------------------------------------------------------------
module rmq_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    stall_o,
  input  logic [rmq_pkg::K_W-1:0] k_i,
  input  rmq_pkg::rt_t            rt_i,
  output logic                    valid_o,
  input  logic                    stall_i,
  output rmq_pkg::out_t           item_o
);

  localparam int OW = rmq_pkg::OP_W;
  localparam int PW = rmq_pkg::PROD_W;
  localparam int RW = rmq_pkg::RND_W;
  localparam logic [PW-1:0] Half = PW'(1 << (rmq_pkg::FRAC_BITS - 1));

  typedef struct packed {
    logic [2:0]                 neg;
    logic [PW-1:0]              pa;
    logic [PW-1:0]              pb;
    logic [PW-1:0]              pc;
    logic signed [rmq_pkg::DW-1:0] half;
    rmq_pkg::branch_e           br;
    logic                       degen;
  } mul_t;

  logic                       vm_q, vo_q;
  logic                       stl_m, stl_o;
  mul_t                       mul_d, mul_q;
  rmq_pkg::out_t              out_d, out_q;
  logic [OW-1:0]              ma, mb, mc;
  logic signed [rmq_pkg::DW-1:0] ra, rb, rc;

  function automatic logic [OW-1:0] mag(logic signed [OW-1:0] v);
    return v[OW-1] ? OW'(-v) : OW'(v);
  endfunction

  function automatic logic signed [rmq_pkg::DW-1:0] rnd_sat(logic [PW-1:0] p, logic neg);
    logic [RW-1:0] r;
    logic [PW-1:0] sum;
    sum = p + Half;
    r   = sum[PW-1:rmq_pkg::FRAC_BITS];
    if (!neg) begin
      return (r > RW'(32767)) ? 16'sd32767 : rmq_pkg::DW'(r);
    end else begin
      return (r > RW'(32768)) ? -16'sd32768 : rmq_pkg::DW'(-r);
    end
  endfunction

  always_comb begin
    ma = mag(rt_i.fr.opa);
    mb = mag(rt_i.fr.opb);
    mc = mag(rt_i.fr.opc);
    mul_d.neg   = {rt_i.fr.opa[OW-1], rt_i.fr.opb[OW-1], rt_i.fr.opc[OW-1]};
    mul_d.pa    = PW'(ma) * PW'(k_i);
    mul_d.pb    = PW'(mb) * PW'(k_i);
    mul_d.pc    = PW'(mc) * PW'(k_i);
    mul_d.half  = rmq_pkg::DW'((rmq_pkg::ROOT_W+1)'(rt_i.root) + 1'b1 >> 1);
    mul_d.br    = rt_i.fr.br;
    mul_d.degen = rt_i.fr.degen;
  end

  always_comb begin
    ra = rnd_sat(mul_q.pa, mul_q.neg[2]);
    rb = rnd_sat(mul_q.pb, mul_q.neg[1]);
    rc = rnd_sat(mul_q.pc, mul_q.neg[0]);
    out_d.branch_taken = mul_q.br;
    out_d.degenerate   = mul_q.degen;
    case (mul_q.br)
      rmq_pkg::BR_TRACE: begin
        out_d.qw = mul_q.half; out_d.qx = ra; out_d.qy = rb; out_d.qz = rc;
      end
      rmq_pkg::BR_XDOM: begin
        out_d.qx = mul_q.half; out_d.qy = ra; out_d.qz = rb; out_d.qw = rc;
      end
      rmq_pkg::BR_YDOM: begin
        out_d.qy = mul_q.half; out_d.qx = ra; out_d.qz = rb; out_d.qw = rc;
      end
      default: begin
        out_d.qz = mul_q.half; out_d.qx = ra; out_d.qy = rb; out_d.qw = rc;
      end
    endcase
    if (mul_q.degen) begin
      out_d.qw = '0; out_d.qx = '0; out_d.qy = '0; out_d.qz = '0;
    end
  end

  assign stl_o   = vo_q && stall_i;
  assign stl_m   = vm_q && stl_o;
  assign stall_o = stl_m;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (!stl_m) begin
        vm_q <= valid_i;
      end
      if (!stl_o) begin
        vo_q <= vm_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stl_m) begin
      mul_q <= mul_d;
    end
    if (!stl_o) begin
      out_q <= out_d;
    end
  end

  assign valid_o = vo_q;
  assign item_o  = out_q;

endmodule

// ===== hdl/rmq_checker.sv =====
// ----------------------------------------------------------------------------
// rmq_checker
// port-level checks of the quaternion conversion core
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rmq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input rmq_pkg::out_t out_item_o
);

  `RMQ_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "output item dropped")
  `RMQ_ASSERT(a_stall_full, in_stall_o |-> out_valid_o && out_stall_i, "input stalled with free room")
  `RMQ_ASSERT(a_degen_zero, out_valid_o && out_item_o.degenerate |-> out_item_o.qw == 16'sd0 && out_item_o.qx == 16'sd0 && out_item_o.qy == 16'sd0 && out_item_o.qz == 16'sd0, "degenerate item not zero")
  `RMQ_ASSERT(a_trace_w, out_valid_o && out_item_o.branch_taken == rmq_pkg::BR_TRACE && !out_item_o.degenerate |-> !out_item_o.qw[15], "trace branch with negative w")

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker u_rmq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// checks the matrix to quaternion pipeline against an in-bench predictor,
// with directed corner matrices, random rotations and noise, and random idling
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 14;
  localparam int LIMIT   = 400000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  rmq_pkg::in_t  in_item_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  rmq_pkg::out_t out_item_o;

  rmq_pkg::in_t  pending_q[$];
  rmq_pkg::out_t quat_q[$];
  int   send_idle = 0;
  int   recv_idle = 0;
  bit   hold_off = 1'b0;
  bit   failed = 1'b0;
  int   cycles = 0;
  logic in_taken = 1'b0;

  rotation_matrix_to_quaternion_core dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint scale_k(longint val, longint k);
    longint mag;
    longint p;
    mag = (val < 0) ? -val : val;
    p = (mag * k + (64'sd1 <<< (rmq_pkg::FRAC_BITS - 1))) >>> rmq_pkg::FRAC_BITS;
    return (val < 0) ? -p : p;
  endfunction

  function automatic logic signed [rmq_pkg::DW-1:0] sat(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return rmq_pkg::DW'(v);
  endfunction

  function automatic rmq_pkg::out_t predict_quat(rmq_pkg::in_t m);
    longint e11, e12, e13, e21, e22, e23, e31, e32, e33;
    longint one, tr, arg, a, b, c, w, x, y, z, root, k, half;
    rmq_pkg::branch_e br;
    rmq_pkg::out_t r;
    e11 = m.m11; e12 = m.m12; e13 = m.m13;
    e21 = m.m21; e22 = m.m22; e23 = m.m23;
    e31 = m.m31; e32 = m.m32; e33 = m.m33;
    one = 64'sd1 <<< rmq_pkg::FRAC_BITS;
    tr = e11 + e22 + e33;
    w = 0; x = 0; y = 0; z = 0;
    if (tr > 0) begin
      br = rmq_pkg::BR_TRACE; arg = tr + one;
      a = e32 - e23; b = e13 - e31; c = e21 - e12;
    end else if (e11 >= e22 && e11 >= e33) begin
      br = rmq_pkg::BR_XDOM; arg = e11 - e22 - e33 + one;
      a = e12 + e21; b = e13 + e31; c = e32 - e23;
    end else if (e22 >= e33) begin
      br = rmq_pkg::BR_YDOM; arg = e22 - e11 - e33 + one;
      a = e12 + e21; b = e23 + e32; c = e13 - e31;
    end else begin
      br = rmq_pkg::BR_ZDOM; arg = e33 - e22 - e11 + one;
      a = e13 + e31; b = e23 + e32; c = e21 - e12;
    end
    r.degenerate = (arg <= 0);
    if (arg > 0) begin
      root = int_sqrt(arg << rmq_pkg::FRAC_BITS);
      k = ((64'sd1 <<< (2 * rmq_pkg::FRAC_BITS)) + root) / (2 * root);
      half = (root + 1) >>> 1;
      case (br)
        rmq_pkg::BR_TRACE: begin
          w = half; x = scale_k(a, k); y = scale_k(b, k); z = scale_k(c, k);
        end
        rmq_pkg::BR_XDOM: begin
          x = half; y = scale_k(a, k); z = scale_k(b, k); w = scale_k(c, k);
        end
        rmq_pkg::BR_YDOM: begin
          y = half; x = scale_k(a, k); z = scale_k(b, k); w = scale_k(c, k);
        end
        default: begin
          z = half; x = scale_k(a, k); y = scale_k(b, k); w = scale_k(c, k);
        end
      endcase
    end
    r.qw = sat(w); r.qx = sat(x); r.qy = sat(y); r.qz = sat(z);
    r.branch_taken = br;
    return r;
  endfunction

  function automatic rmq_pkg::in_t diag(int d1, int d2, int d3);
    rmq_pkg::in_t m;
    m = '0;
    m.m11 = rmq_pkg::DW'(d1); m.m22 = rmq_pkg::DW'(d2); m.m33 = rmq_pkg::DW'(d3);
    return m;
  endfunction

  function automatic rmq_pkg::in_t rand_item();
    rmq_pkg::in_t m;
    m = $bits(rmq_pkg::in_t)'({$urandom, $urandom, $urandom, $urandom, $urandom});
    return m;
  endfunction

  // near-rotation: random unit-ish quaternion to matrix with jitter
  function automatic rmq_pkg::in_t rand_rotation();
    real qa, qb, qc, qd, n;
    rmq_pkg::in_t m;
    qa = $urandom_range(2000) - 1000.0; qb = $urandom_range(2000) - 1000.0;
    qc = $urandom_range(2000) - 1000.0; qd = $urandom_range(2000) - 1000.0;
    n = $sqrt(qa * qa + qb * qb + qc * qc + qd * qd) + 1e-9;
    qa /= n; qb /= n; qc /= n; qd /= n;
    m.m11 = rmq_pkg::DW'($rtoi(16384.0 * (1 - 2 * (qc * qc + qd * qd)))
                         + $urandom_range(4) - 2);
    m.m12 = rmq_pkg::DW'($rtoi(16384.0 * 2 * (qb * qc - qd * qa)) + $urandom_range(4) - 2);
    m.m13 = rmq_pkg::DW'($rtoi(16384.0 * 2 * (qb * qd + qc * qa)) + $urandom_range(4) - 2);
    m.m21 = rmq_pkg::DW'($rtoi(16384.0 * 2 * (qb * qc + qd * qa)) + $urandom_range(4) - 2);
    m.m22 = rmq_pkg::DW'($rtoi(16384.0 * (1 - 2 * (qb * qb + qd * qd)))
                         + $urandom_range(4) - 2);
    m.m23 = rmq_pkg::DW'($rtoi(16384.0 * 2 * (qc * qd - qb * qa)) + $urandom_range(4) - 2);
    m.m31 = rmq_pkg::DW'($rtoi(16384.0 * 2 * (qb * qd - qc * qa)) + $urandom_range(4) - 2);
    m.m32 = rmq_pkg::DW'($rtoi(16384.0 * 2 * (qc * qd + qb * qa)) + $urandom_range(4) - 2);
    m.m33 = rmq_pkg::DW'($rtoi(16384.0 * (1 - 2 * (qb * qb + qc * qc)))
                         + $urandom_range(4) - 2);
    return m;
  endfunction

  // the driver runs on the falling edge; sample acceptance at the rising edge here
  always @(posedge clk_i) in_taken <= in_valid_i && !in_stall_o;

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        quat_q.push_back(predict_quat(in_item_i));
        void'(pending_q.pop_front());
      end
      if (!in_valid_i || in_taken) begin
        if (pending_q.size() > 0 && !hold_off && $urandom_range(99) >= send_idle) begin
          in_valid_i <= 1'b1;
          in_item_i  <= pending_q[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rmq_pkg::out_t exp_q;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (quat_q.size() == 0) begin
        $display("%0t unexpected item %h", $realtime, out_item_o);
        failed <= 1'b1;
      end else begin
        exp_q = quat_q.pop_front();
        if (exp_q !== out_item_o) begin
          $display("%0t mismatch expected qw %0d qx %0d qy %0d qz %0d br %0d dg %0b",
                   $realtime, exp_q.qw, exp_q.qx, exp_q.qy, exp_q.qz,
                   exp_q.branch_taken, exp_q.degenerate);
          $display("%0t          actual   qw %0d qx %0d qy %0d qz %0d br %0d dg %0b",
                   $realtime, out_item_o.qw, out_item_o.qx, out_item_o.qy,
                   out_item_o.qz, out_item_o.branch_taken, out_item_o.degenerate);
          failed <= 1'b1;
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("[rotation_matrix_to_quaternion_core] ERROR");
      $finish;
    end
  end

  task automatic run_phase(int n, int s_idle, int r_idle);
    int j;
    send_idle = s_idle;
    recv_idle = r_idle;
    for (j = 0; j < n; j++) begin
      case ($urandom_range(9))
        0, 1:    pending_q.push_back(rand_item());
        2:       pending_q.push_back(diag($urandom_range(65535), $urandom_range(65535),
                                          $urandom_range(65535)));
        default: pending_q.push_back(rand_rotation());
      endcase
    end
    while (pending_q.size() > 0 || in_valid_i) @(posedge clk_i);
  endtask

  initial begin
    rmq_pkg::in_t m;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    // directed: identity, half turns, ties, extremes, degenerate, saturation
    pending_q.push_back(diag(16384, 16384, 16384));
    pending_q.push_back(diag(16384, -16384, -16384));
    pending_q.push_back(diag(-16384, 16384, -16384));
    pending_q.push_back(diag(-16384, -16384, 16384));
    pending_q.push_back(diag(0, 0, 0));
    pending_q.push_back(diag(-100, -100, -100));
    pending_q.push_back(diag(-100, -100, 50));
    pending_q.push_back(diag(-100, 50, 50));
    pending_q.push_back(diag(-32768, -32768, -32768));
    pending_q.push_back(diag(32767, 32767, 32767));
    pending_q.push_back(diag(-32768, 32767, 32767));
    pending_q.push_back(diag(-20000, -20000, 32767));
    pending_q.push_back(diag(-1, -16384, 0));
    pending_q.push_back('1);
    m = diag(-16384, -16384, -16384);
    m.m12 = 16'sh7fff; m.m21 = 16'sh7fff; m.m13 = 16'sh7fff; m.m31 = 16'sh7fff;
    pending_q.push_back(m);
    m = diag(1, 0, 0); m.m32 = 16'sh7fff; m.m23 = 16'sh8000; m.m13 = 16'sh8000;
    m.m31 = 16'sh7fff; m.m21 = 16'sh7fff; m.m12 = 16'sh8000;
    pending_q.push_back(m);
    m = {9{16'h8000}};
    pending_q.push_back(m);
    m = {9{16'h7fff}};
    pending_q.push_back(m);
    m = diag(-32768, -32768, 16000); m.m23 = 16'sh7fff; m.m32 = 16'sh7fff;
    pending_q.push_back(m);
    while (pending_q.size() > 0 || in_valid_i) @(posedge clk_i);
    run_phase(350, 0, 0);
    hold_off = 1'b1;
    while (quat_q.size() > 0) @(posedge clk_i);
    hold_off = 1'b0;
    run_phase(350, 81, 0);
    run_phase(350, 0, 81);
    run_phase(350, 24, 24);
    recv_idle = 0;
    while (quat_q.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    if (!failed && quat_q.size() == 0) begin
      $display("[rotation_matrix_to_quaternion_core] OK");
    end else begin
      $display("[rotation_matrix_to_quaternion_core] ERROR");
    end
    $finish;
  end
endmodule
